### rtl/core/icaf_pkg.sv
`default_nettype none
package icaf_pkg;

    // calibration and cordic sizing
    localparam int CAL_SAMPLES  = 1000;
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int CORDIC_CNT_W = $clog2(CORDIC_ITERS + 1);

    // offset = sum / CAL_SAMPLES by reciprocal multiply, exact for 32-bit magnitudes
    localparam int CAL_SHIFT = 32 + $clog2(CAL_SAMPLES);
    localparam logic [33:0] CAL_RECIP =
        34'(((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    // lane micro-sequence length
    localparam int LANE_STEPS = 10;
    localparam logic [3:0] LANE_LAST = 4'(LANE_STEPS - 1);

    // Q0.16 filter and blend weights
    localparam logic signed [32:0] W_GYRO_NEW = 33'sd52429;
    localparam logic signed [32:0] W_GYRO_OLD = 33'sd13107;
    localparam logic signed [32:0] W_ACC_NEW  = 33'sd6554;
    localparam logic signed [32:0] W_ACC_OLD  = 33'sd58982;
    localparam logic signed [32:0] W_KEEP     = 33'sd64881;
    localparam logic signed [32:0] W_TILT     = 33'sd655;

    localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;

    // input opcodes
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CAL     = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_GYRO_SCALE      = 3'd0,
        CFG_ACCEL_SCALE     = 3'd1,
        CFG_SAMPLE_PERIOD   = 3'd2,
        CFG_ACCEL_TOLERANCE = 3'd3,
        CFG_ANGLE_TOLERANCE = 3'd4,
        CFG_RATE_TOLERANCE  = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL,
        ST_LANE_GO,
        ST_LANE_WAIT,
        ST_TILT_GO,
        ST_TILT_WAIT,
        ST_BLEND_GO,
        ST_BLEND_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              opcode;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] roll_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] yaw_angle;
        logic signed [31:0] roll_rate;
        logic signed [31:0] pitch_rate;
        logic signed [31:0] yaw_rate;
        logic               is_level;
        logic               rate_zero;
        logic               calibrated;
    } out_t;

    typedef struct packed {
        logic signed [16:0] gyro_delta;
        logic signed [15:0] accel;
        logic signed [31:0] rate_old;
        logic signed [31:0] accel_old;
        logic signed [31:0] angle_old;
        logic [31:0]        gyro_lsb;
        logic [31:0]        accel_lsb;
        logic [31:0]        sample_period;
    } lane_in_t;

    typedef struct packed {
        logic signed [31:0] rate;
        logic signed [31:0] accel;
        logic signed [31:0] angle;
    } lane_out_t;

    typedef struct packed {
        logic signed [31:0] roll_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] roll_tilt;
        logic signed [31:0] pitch_tilt;
        logic               roll_en;
        logic               pitch_en;
    } merge_in_t;

    // round half up after a 16-bit shift, saturate to 32 bits
    function automatic logic signed [31:0] sat_rnd16(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = (v + 66'sd32768) >>> 16;
        if (t > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (t < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return t[31:0];
    endfunction

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -35'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // magnitude of a 32-bit signed value, most negative maps to 2^31
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    // atan(2^-i) in Q2.30
    function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
        logic signed [34:0] r;
        case (i)
            5'd0:    r = 35'sd843314857;
            5'd1:    r = 35'sd497837829;
            5'd2:    r = 35'sd263043837;
            5'd3:    r = 35'sd133525159;
            5'd4:    r = 35'sd67021687;
            5'd5:    r = 35'sd33543516;
            5'd6:    r = 35'sd16775851;
            5'd7:    r = 35'sd8388437;
            5'd8:    r = 35'sd4194283;
            5'd9:    r = 35'sd2097149;
            5'd31:   r = 35'sd1;
            default: r = 35'sd1 <<< (30 - 32'(i));
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/imu_complementary_attitude_filter_top.sv
`default_nettype none
// Six-axis IMU complementary attitude filter. One transaction on s_ gives exactly one on m_.
// A calibration transaction goes straight to the done state and its result then loads into the
// output register; the transaction that completes calibration first runs the offset divide,
// one axis per cycle, in the calibration state. A measurement transaction runs three axis
// lanes side by side, each a 10-step sequence on its own multiplier, then the roll and pitch
// CORDIC units run CORDIC_STEPS (20) vectoring steps side by side, then a 3-step blend, with
// go and wait states handing over between the stages before the output load. Items are
// processed one at a time and the input is ready again once the result loads; a finished
// result sits in the output register so the next transaction can be taken while it waits,
// and a second result holds the block until the first one is taken. Configuration is written
// through cfg_we/cfg_addr/cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce.
module imu_complementary_attitude_filter_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire icaf_pkg::in_t  s_payload,
    output logic                m_valid,
    input  wire logic           m_ready,
    output icaf_pkg::out_t      m_payload,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_addr,
    input  wire logic [31:0]    cfg_wdata
);
    import icaf_pkg::*;

    // configuration
    logic [31:0] gyro_lsb_reg;
    logic [31:0] accel_lsb_reg;
    logic [31:0] sample_period_reg;
    logic [30:0] tilt_min_reg;
    logic [30:0] angle_tol_reg;
    logic [30:0] rate_tol_reg;

    // filter state
    logic signed [15:0] offset_reg [3];
    logic signed [31:0] rate_reg [3];
    logic signed [31:0] accel_reg [3];
    logic signed [31:0] angle_reg [3];
    logic signed [31:0] sum_reg [3];
    logic [15:0]        cal_count_reg;
    logic               ready_reg;

    state_t             st_reg;
    state_t             st_next;
    in_t                in_reg;
    logic [1:0]         cal_idx_reg;
    logic [65:0]        cal_prod_reg;
    logic               cal_neg_reg;
    logic signed [31:0] cal_sel;
    logic [15:0]        cal_quot;
    logic               cal_last;
    logic               accept;
    logic               lane_start;
    logic               tilt_start;
    logic               merge_start;
    logic               out_load;
    logic               m_valid_reg;
    out_t               m_payload_reg;

    lane_in_t           lane_in [3];
    lane_out_t          lane_out [3];
    logic [2:0]         lane_done;
    logic signed [15:0] gyro_in [3];
    logic signed [15:0] accel_in [3];

    logic               roll_done;
    logic               pitch_done;
    logic signed [31:0] roll_tilt;
    logic signed [31:0] pitch_tilt;
    merge_in_t          merge_in;
    logic               merge_done;
    logic signed [31:0] roll_blend;
    logic signed [31:0] pitch_blend;

    assign accept   = s_valid && s_ready;
    assign cal_last = (17'(cal_count_reg) + 17'd1) >= 17'(CAL_SAMPLES);

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_payload.opcode == OP_CAL) begin
                        st_next = (!ready_reg && cal_last) ? ST_CAL : ST_DONE;
                    end else begin
                        st_next = ST_LANE_GO;
                    end
                end
            end
            ST_CAL:        st_next = (cal_idx_reg == 2'd3) ? ST_DONE : ST_CAL;
            ST_LANE_GO:    st_next = ST_LANE_WAIT;
            ST_LANE_WAIT:  st_next = (&lane_done) ? ST_TILT_GO : ST_LANE_WAIT;
            ST_TILT_GO:    st_next = ST_TILT_WAIT;
            ST_TILT_WAIT:  st_next = (roll_done && pitch_done) ? ST_BLEND_GO : ST_TILT_WAIT;
            ST_BLEND_GO:   st_next = ST_BLEND_WAIT;
            ST_BLEND_WAIT: st_next = merge_done ? ST_DONE : ST_BLEND_WAIT;
            ST_DONE:       st_next = (!m_valid_reg || m_ready) ? ST_IDLE : ST_DONE;
            default:       st_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready     = (st_reg == ST_IDLE);
        lane_start  = (st_reg == ST_LANE_GO);
        tilt_start  = (st_reg == ST_TILT_GO);
        merge_start = (st_reg == ST_BLEND_GO);
        out_load    = (st_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    // offset divide operand
    always_comb begin
        case (cal_idx_reg)
            2'd0:    cal_sel = sum_reg[0];
            2'd1:    cal_sel = sum_reg[1];
            2'd2:    cal_sel = sum_reg[2];
            default: cal_sel = '0;
        endcase
    end

    assign cal_quot = 16'(cal_prod_reg >> CAL_SHIFT);

    always_ff @(posedge aclk) begin
        cal_prod_reg <= 66'(mag32(cal_sel)) * 66'(CAL_RECIP);
        cal_neg_reg  <= cal_sel[31];
        if (accept) begin
            in_reg <= s_payload;
        end
    end

    // configuration, state and sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg            <= ST_IDLE;
            gyro_lsb_reg      <= 32'd4570000;
            accel_lsb_reg     <= 32'd262144;
            sample_period_reg <= 32'd21474837;
            tilt_min_reg      <= 31'd6554;
            angle_tol_reg     <= 31'd6554;
            rate_tol_reg      <= 31'd6554;
            for (int k = 0; k < 3; k++) begin
                offset_reg[k] <= '0;
                rate_reg[k]   <= '0;
                accel_reg[k]  <= '0;
                angle_reg[k]  <= '0;
                sum_reg[k]    <= '0;
            end
            cal_count_reg <= '0;
            ready_reg     <= 1'b0;
            cal_idx_reg   <= '0;
        end else begin
            st_reg <= st_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_GYRO_SCALE:      gyro_lsb_reg      <= cfg_wdata;
                    CFG_ACCEL_SCALE:     accel_lsb_reg     <= cfg_wdata;
                    CFG_SAMPLE_PERIOD:   sample_period_reg <= cfg_wdata;
                    CFG_ACCEL_TOLERANCE: tilt_min_reg      <= cfg_wdata[30:0];
                    CFG_ANGLE_TOLERANCE: angle_tol_reg     <= cfg_wdata[30:0];
                    CFG_RATE_TOLERANCE:  rate_tol_reg      <= cfg_wdata[30:0];
                    default:             gyro_lsb_reg      <= gyro_lsb_reg;
                endcase
            end
            // calibration accumulate
            if (accept && s_payload.opcode == OP_CAL && !ready_reg) begin
                sum_reg[0]    <= sum_reg[0] + 32'(s_payload.gyro_x);
                sum_reg[1]    <= sum_reg[1] + 32'(s_payload.gyro_y);
                sum_reg[2]    <= sum_reg[2] + 32'(s_payload.gyro_z);
                cal_count_reg <= cal_last ? 16'd0 : cal_count_reg + 16'd1;
                cal_idx_reg   <= '0;
            end
            // offset divide, one axis per cycle
            if (st_reg == ST_CAL) begin
                cal_idx_reg <= cal_idx_reg + 2'd1;
                if (cal_idx_reg != 2'd0) begin
                    offset_reg[cal_idx_reg - 2'd1] <= cal_neg_reg ? -cal_quot : cal_quot;
                end
                if (cal_idx_reg == 2'd3) begin
                    for (int k = 0; k < 3; k++) begin
                        sum_reg[k] <= '0;
                    end
                    ready_reg <= 1'b1;
                end
            end
            // lane results
            if (st_reg == ST_LANE_WAIT && (&lane_done)) begin
                for (int k = 0; k < 3; k++) begin
                    rate_reg[k]  <= lane_out[k].rate;
                    accel_reg[k] <= lane_out[k].accel;
                    angle_reg[k] <= lane_out[k].angle;
                end
            end
            // tilt correction result
            if (st_reg == ST_BLEND_WAIT && merge_done) begin
                angle_reg[0] <= roll_blend;
                angle_reg[1] <= pitch_blend;
            end
        end
    end

    // axis lanes
    assign gyro_in[0]  = in_reg.gyro_x;
    assign gyro_in[1]  = in_reg.gyro_y;
    assign gyro_in[2]  = in_reg.gyro_z;
    assign accel_in[0] = in_reg.accel_x;
    assign accel_in[1] = in_reg.accel_y;
    assign accel_in[2] = in_reg.accel_z;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        always_comb begin
            lane_in[g].gyro_delta    = 17'(gyro_in[g]) - 17'(offset_reg[g]);
            lane_in[g].accel         = accel_in[g];
            lane_in[g].rate_old      = rate_reg[g];
            lane_in[g].accel_old     = accel_reg[g];
            lane_in[g].angle_old     = angle_reg[g];
            lane_in[g].gyro_lsb      = gyro_lsb_reg;
            lane_in[g].accel_lsb     = accel_lsb_reg;
            lane_in[g].sample_period = sample_period_reg;
        end

        icaf_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (lane_start),
            .lane_in  (lane_in[g]),
            .done     (lane_done[g]),
            .lane_out (lane_out[g])
        );
    end

    // tilt from filtered accels
    icaf_cordic u_roll_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tilt_start),
        .y_in    (33'(accel_reg[1])),
        .x_in    (33'(accel_reg[2])),
        .done    (roll_done),
        .angle   (roll_tilt)
    );

    icaf_cordic u_pitch_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tilt_start),
        .y_in    (-33'(accel_reg[0])),
        .x_in    (33'(accel_reg[2])),
        .done    (pitch_done),
        .angle   (pitch_tilt)
    );

    always_comb begin
        merge_in.roll_angle  = angle_reg[0];
        merge_in.pitch_angle = angle_reg[1];
        merge_in.roll_tilt   = roll_tilt;
        merge_in.pitch_tilt  = pitch_tilt;
        merge_in.roll_en     = (mag32(accel_reg[1]) > {1'b0, tilt_min_reg}) ||
                               (mag32(accel_reg[2]) > {1'b0, tilt_min_reg});
        merge_in.pitch_en    = (mag32(accel_reg[0]) > {1'b0, tilt_min_reg}) ||
                               (mag32(accel_reg[2]) > {1'b0, tilt_min_reg});
    end

    icaf_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (merge_start),
        .merge_in  (merge_in),
        .done      (merge_done),
        .roll_out  (roll_blend),
        .pitch_out (pitch_blend)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_payload_reg.roll_angle  <= angle_reg[0];
            m_payload_reg.pitch_angle <= angle_reg[1];
            m_payload_reg.yaw_angle   <= angle_reg[2];
            m_payload_reg.roll_rate   <= rate_reg[0];
            m_payload_reg.pitch_rate  <= rate_reg[1];
            m_payload_reg.yaw_rate    <= rate_reg[2];
            m_payload_reg.is_level    <= (mag32(angle_reg[0]) < {1'b0, angle_tol_reg}) &&
                                         (mag32(angle_reg[1]) < {1'b0, angle_tol_reg});
            m_payload_reg.rate_zero   <= (mag32(rate_reg[0]) < {1'b0, rate_tol_reg}) &&
                                         (mag32(rate_reg[1]) < {1'b0, rate_tol_reg}) &&
                                         (mag32(rate_reg[2]) < {1'b0, rate_tol_reg});
            m_payload_reg.calibrated  <= ready_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
`default_nettype wire

### rtl/core/icaf_lane.sv
`default_nettype none
module icaf_lane (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire icaf_pkg::lane_in_t lane_in,
    output logic                    done,
    output icaf_pkg::lane_out_t     lane_out
);
    import icaf_pkg::*;

    logic               busy_reg;
    logic [3:0]         step_reg;
    logic               done_reg;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] tmp_reg;
    logic signed [31:0] rate_reg;
    logic signed [31:0] accel_reg;
    logic signed [31:0] angle_reg;
    logic signed [65:0] step_rnd;
    logic signed [34:0] angle_sum;

    // step sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (step_reg == LANE_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == LANE_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd0: begin
                mul_a = 33'(lane_in.gyro_delta);
                mul_b = {1'b0, lane_in.gyro_lsb};
            end
            4'd2: begin
                mul_a = 33'(tmp_reg);
                mul_b = W_GYRO_NEW;
            end
            4'd3: begin
                mul_a = 33'(lane_in.rate_old);
                mul_b = W_GYRO_OLD;
            end
            4'd4: begin
                mul_a = 33'(lane_in.accel);
                mul_b = {1'b0, lane_in.accel_lsb};
            end
            4'd6: begin
                mul_a = 33'(tmp_reg);
                mul_b = W_ACC_NEW;
            end
            4'd7: begin
                mul_a = 33'(lane_in.accel_old);
                mul_b = W_ACC_OLD;
            end
            4'd8: begin
                mul_a = 33'(rate_reg);
                mul_b = {1'b0, lane_in.sample_period};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // angle step rounded at 2^32, then saturating add
    assign step_rnd  = (prod_reg + (66'sd1 <<< 31)) >>> 32;
    assign angle_sum = 35'(lane_in.angle_old) + step_rnd[34:0];

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (busy_reg) begin
            case (step_reg)
                4'd1:    tmp_reg   <= sat_rnd16(prod_reg);
                4'd3:    acc_reg   <= prod_reg;
                4'd4:    rate_reg  <= sat_rnd16(acc_reg + prod_reg);
                4'd5:    tmp_reg   <= sat_rnd16(prod_reg);
                4'd7:    acc_reg   <= prod_reg;
                4'd8:    accel_reg <= sat_rnd16(acc_reg + prod_reg);
                4'd9:    angle_reg <= sat35(angle_sum);
                default: acc_reg   <= acc_reg;
            endcase
        end
    end

    assign done           = done_reg;
    assign lane_out.rate  = rate_reg;
    assign lane_out.accel = accel_reg;
    assign lane_out.angle = angle_reg;

endmodule
`default_nettype wire

### rtl/core/icaf_cordic.sv
`default_nettype none
module icaf_cordic (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [32:0] y_in,
    input  wire logic signed [32:0] x_in,
    output logic                    done,
    output logic signed [31:0]      angle
);
    import icaf_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CORDIC_CNT_W-1:0] iter_reg;
    logic                    zero_reg;
    logic signed [55:0]      x_reg;
    logic signed [55:0]      y_reg;
    logic signed [34:0]      z_reg;
    logic signed [32:0]      xf;
    logic signed [32:0]      yf;
    logic signed [34:0]      zf;
    logic signed [55:0]      xs;
    logic signed [55:0]      ys;
    logic signed [34:0]      a_step;
    logic signed [34:0]      z_rnd;

    // fold a negative x by +-pi
    always_comb begin
        if (x_in[32]) begin
            xf = -x_in;
            yf = -y_in;
            zf = y_in[32] ? -PI_Q30 : PI_Q30;
        end else begin
            xf = x_in;
            yf = y_in;
            zf = '0;
        end
    end

    assign xs     = x_reg >>> iter_reg;
    assign ys     = y_reg >>> iter_reg;
    assign a_step = atan_q30(5'(iter_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= busy_reg && (iter_reg == CORDIC_CNT_W'(CORDIC_ITERS - 1));
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == CORDIC_CNT_W'(CORDIC_ITERS - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // one vectoring rotation per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= 56'(xf) <<< 20;
            y_reg    <= 56'(yf) <<< 20;
            z_reg    <= zf;
            zero_reg <= (x_in == '0) && (y_in == '0);
        end else if (busy_reg) begin
            if (!y_reg[55]) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + a_step;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - a_step;
            end
        end
    end

    assign z_rnd = (z_reg + 35'sd8192) >>> 14;
    assign done  = done_reg;
    assign angle = zero_reg ? 32'sd0 : 32'(z_rnd);

endmodule
`default_nettype wire

### rtl/core/icaf_merge.sv
`default_nettype none
module icaf_merge (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire icaf_pkg::merge_in_t merge_in,
    output logic                     done,
    output logic signed [31:0]       roll_out,
    output logic signed [31:0]       pitch_out
);
    import icaf_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [1:0]         step_reg;
    logic signed [32:0] roll_a;
    logic signed [32:0] roll_b;
    logic signed [32:0] pitch_a;
    logic signed [32:0] pitch_b;
    logic signed [65:0] roll_prod_reg;
    logic signed [65:0] pitch_prod_reg;
    logic signed [65:0] roll_acc_reg;
    logic signed [65:0] pitch_acc_reg;
    logic signed [31:0] roll_reg;
    logic signed [31:0] pitch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && (step_reg == 2'd2);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // keep weight on the integrated angle first, then tilt weight
    always_comb begin
        if (step_reg == 2'd0) begin
            roll_a  = 33'(merge_in.roll_angle);
            pitch_a = 33'(merge_in.pitch_angle);
            roll_b  = W_KEEP;
            pitch_b = W_KEEP;
        end else begin
            roll_a  = 33'(merge_in.roll_tilt);
            pitch_a = 33'(merge_in.pitch_tilt);
            roll_b  = W_TILT;
            pitch_b = W_TILT;
        end
    end

    always_ff @(posedge aclk) begin
        roll_prod_reg  <= roll_a * roll_b;
        pitch_prod_reg <= pitch_a * pitch_b;
        if (busy_reg && step_reg == 2'd1) begin
            roll_acc_reg  <= roll_prod_reg;
            pitch_acc_reg <= pitch_prod_reg;
        end
        if (busy_reg && step_reg == 2'd2) begin
            roll_reg  <= merge_in.roll_en ? sat_rnd16(roll_acc_reg + roll_prod_reg)
                                          : merge_in.roll_angle;
            pitch_reg <= merge_in.pitch_en ? sat_rnd16(pitch_acc_reg + pitch_prod_reg)
                                           : merge_in.pitch_angle;
        end
    end

    assign done      = done_reg;
    assign roll_out  = roll_reg;
    assign pitch_out = pitch_reg;

endmodule
`default_nettype wire

### rtl/core/icaf_checker.sv
`default_nettype none
module icaf_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire icaf_pkg::out_t m_payload
);
    import icaf_pkg::*;

    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // one transaction in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // reset leaves the block empty and ready
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    // a result only appears after some transaction was taken earlier
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready || !$past(s_ready))
        else $error("result with no transaction in flight");

endmodule

bind imu_complementary_attitude_filter_top icaf_checker u_icaf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import icaf_pkg::*;

    localparam int CAL_COUNT   = 1000;
    localparam int TILT_STEPS  = 20;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT = 200000;
    localparam longint Q30_PI  = 64'sd3373259426;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_payload;
    logic        m_valid;
    logic        m_ready;
    out_t        m_payload;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    imu_complementary_attitude_filter_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // filter state mirror
    longint rate_lsb, accel_gain, dt_gain, tilt_floor, level_tol, still_tol;
    longint offs [3];
    longint rates [3];
    longint accs [3];
    longint angles [3];
    longint cal_sums [3];
    int     cal_seen;
    bit     cal_done;

    out_t   attitude_queue [$];
    int     error_count;
    longint cycle_count;
    bit     quiet_tail;

    function automatic longint floor_div(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_div(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint absv(longint v);
        return v < 0 ? -v : v;
    endfunction

    // atan(2^-i) in Q2.30 by power series, with a constant for i = 0
    function automatic longint atan_step(int i);
        longint acc;
        longint t;
        acc = 0;
        if (i == 0) return 64'sd843314857;
        for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
            t = (64'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
            acc = (k % 2) ? acc - t : acc + t;
        end
        return (acc + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // cordic vectoring atan2, Q16.16 in and out
    function automatic longint tilt_angle(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? Q30_PI : -Q30_PI;
            x = -x;
            y = -y;
        end
        x = x * (64'sd1 <<< 20);
        y = y * (64'sd1 <<< 20);
        for (int i = 0; i < TILT_STEPS; i++) begin
            xs = floor_div(x, i);
            ys = floor_div(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_step(i);
            end else begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        return clamp32(rnd_div(z, 14));
    endfunction

    function automatic longint mix_tilt(longint ang, longint tilt);
        return clamp32(rnd_div(ang * 64881 + tilt * 655, 16));
    endfunction

    task automatic reset_mirror();
        rate_lsb = 4570000; accel_gain = 262144; dt_gain = 21474837;
        tilt_floor = 6554; level_tol = 6554; still_tol = 6554;
        for (int k = 0; k < 3; k++) begin
            offs[k] = 0; rates[k] = 0; accs[k] = 0; angles[k] = 0; cal_sums[k] = 0;
        end
        cal_seen = 0;
        cal_done = 0;
    endtask

    // advance mirror by one sample and return the attitude it reports
    task automatic predict_attitude(input in_t item, output out_t res);
        longint gy [3];
        longint ac [3];
        longint r, a, st;
        gy[0] = item.gyro_x; gy[1] = item.gyro_y; gy[2] = item.gyro_z;
        ac[0] = item.accel_x; ac[1] = item.accel_y; ac[2] = item.accel_z;
        if (item.opcode == OP_CAL) begin
            if (!cal_done) begin
                for (int k = 0; k < 3; k++) begin
                    cal_sums[k] = longint'(int'(cal_sums[k] + gy[k]));
                end
                cal_seen++;
                if (cal_seen >= CAL_COUNT) begin
                    for (int k = 0; k < 3; k++) begin
                        offs[k] = longint'(shortint'(cal_sums[k] / CAL_COUNT));
                        cal_sums[k] = 0;
                    end
                    cal_seen = 0;
                    cal_done = 1;
                end
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                r = clamp32(rnd_div((gy[k] - offs[k]) * rate_lsb, 16));
                rates[k] = clamp32(rnd_div(r * 52429 + rates[k] * 13107, 16));
            end
            for (int k = 0; k < 3; k++) begin
                a = clamp32(rnd_div(ac[k] * accel_gain, 16));
                accs[k] = clamp32(rnd_div(a * 6554 + accs[k] * 58982, 16));
            end
            for (int k = 0; k < 3; k++) begin
                st = rnd_div(rates[k] * dt_gain, 32);
                angles[k] = clamp32(angles[k] + st);
            end
            if (absv(accs[1]) > tilt_floor || absv(accs[2]) > tilt_floor)
                angles[0] = mix_tilt(angles[0], tilt_angle(accs[1], accs[2]));
            if (absv(accs[0]) > tilt_floor || absv(accs[2]) > tilt_floor)
                angles[1] = mix_tilt(angles[1], tilt_angle(-accs[0], accs[2]));
        end
        res.roll_angle  = angles[0][31:0];
        res.pitch_angle = angles[1][31:0];
        res.yaw_angle   = angles[2][31:0];
        res.roll_rate   = rates[0][31:0];
        res.pitch_rate  = rates[1][31:0];
        res.yaw_rate    = rates[2][31:0];
        res.is_level    = absv(angles[0]) < level_tol && absv(angles[1]) < level_tol;
        res.rate_zero   = absv(rates[0]) < still_tol && absv(rates[1]) < still_tol
                          && absv(rates[2]) < still_tol;
        res.calibrated  = cal_done;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // result side: compare each taken result
    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (attitude_queue.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    want = attitude_queue.pop_front();
                    if (m_payload.roll_angle != want.roll_angle)
                        report_mismatch("roll_angle", m_payload.roll_angle, want.roll_angle);
                    if (m_payload.pitch_angle != want.pitch_angle)
                        report_mismatch("pitch_angle", m_payload.pitch_angle, want.pitch_angle);
                    if (m_payload.yaw_angle != want.yaw_angle)
                        report_mismatch("yaw_angle", m_payload.yaw_angle, want.yaw_angle);
                    if (m_payload.roll_rate != want.roll_rate)
                        report_mismatch("roll_rate", m_payload.roll_rate, want.roll_rate);
                    if (m_payload.pitch_rate != want.pitch_rate)
                        report_mismatch("pitch_rate", m_payload.pitch_rate, want.pitch_rate);
                    if (m_payload.yaw_rate != want.yaw_rate)
                        report_mismatch("yaw_rate", m_payload.yaw_rate, want.yaw_rate);
                    if (m_payload.is_level != want.is_level)
                        report_mismatch("is_level", m_payload.is_level, want.is_level);
                    if (m_payload.rate_zero != want.rate_zero)
                        report_mismatch("rate_zero", m_payload.rate_zero, want.rate_zero);
                    if (m_payload.calibrated != want.calibrated)
                        report_mismatch("calibrated", m_payload.calibrated, want.calibrated);
                end
            end
        end
    end

    // receiver stall bursts
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // timeout
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // valid stays high between back-to-back transactions, drops only in idle bursts
    task automatic send_sample(input in_t item);
        out_t res;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_attitude(item, res);
        attitude_queue.push_back(res);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (attitude_queue.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_GYRO_SCALE:      rate_lsb   = val;
            CFG_ACCEL_SCALE:     accel_gain = val;
            CFG_SAMPLE_PERIOD:   dt_gain    = val;
            CFG_ACCEL_TOLERANCE: tilt_floor = val[30:0];
            CFG_ANGLE_TOLERANCE: level_tol  = val[30:0];
            CFG_RATE_TOLERANCE:  still_tol  = val[30:0];
            default: ;
        endcase
    endtask

    function automatic in_t random_sample(logic op, int spread);
        in_t s;
        s.opcode  = op;
        s.accel_x = spread ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
        s.accel_y = spread ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
        s.accel_z = spread ? 16'($urandom) : 16'($urandom_range(16000, 16800));
        s.gyro_x  = spread ? 16'($urandom) : 16'($urandom_range(0, 600) - 300);
        s.gyro_y  = spread ? 16'($urandom) : 16'($urandom_range(0, 600) - 300);
        s.gyro_z  = spread ? 16'($urandom) : 16'($urandom_range(0, 600) - 300);
        return s;
    endfunction

    // directed rows: opcode, ax, ay, az, gx, gy, gz, then a typed flag
    typedef struct {
        logic op;
        shortint ax, ay, az, gx, gy, gz;
        bit  typed;
    } row_t;

    row_t rows [] = '{
        '{OP_CAL,     0, 0, 0, 0, 0, 0, 1},
        '{OP_MEASURE, 0, 0, 0, 0, 0, 0, 1},
        '{OP_MEASURE, 32767, 32767, 32767, 32767, 32767, 32767, 0},
        '{OP_MEASURE, -32768, -32768, -32768, -32768, -32768, -32768, 0},
        '{OP_MEASURE, 0, 0, -32768, 0, 0, 0, 0},
        '{OP_MEASURE, 0, -32768, 0, 100, -100, 50, 0},
        '{OP_MEASURE, -32768, 0, 32767, -1, 1, 0, 0},
        '{OP_MEASURE, 0, 0, 0, 0, 0, 0, 0},
        '{OP_CAL,     32767, -32768, 1, 32767, -32768, 1, 0},
        '{OP_MEASURE, 100, -100, 16384, -5, 5, 0, 0}
    };

    initial begin
        in_t    item;
        out_t   zero_res;
        int     spread;
        aresetn = 1'b0; s_valid = 1'b0; s_payload = '0;
        cfg_we = 1'b0; cfg_addr = CFG_GYRO_SCALE; cfg_wdata = '0;
        error_count = 0; cycle_count = 0; quiet_tail = 0;
        reset_mirror();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; first two rows checked directly against a zero result with is_level and rate_zero set
        zero_res = '0;
        zero_res.is_level  = 1'b1;
        zero_res.rate_zero = 1'b1;
        foreach (rows[i]) begin
            item = '{rows[i].op, rows[i].ax, rows[i].ay, rows[i].az,
                     rows[i].gx, rows[i].gy, rows[i].gz};
            send_sample(item);
            if (rows[i].typed && attitude_queue[$] != zero_res)
                report_mismatch("directed row", i, 0);
        end
        drain();

        // extreme register settings
        write_reg(CFG_GYRO_SCALE, 32'hffffffff);
        write_reg(CFG_ACCEL_SCALE, 32'hffffffff);
        write_reg(CFG_SAMPLE_PERIOD, 32'hffffffff);
        write_reg(CFG_ACCEL_TOLERANCE, 32'h7fffffff);
        write_reg(CFG_ANGLE_TOLERANCE, 32'h7fffffff);
        write_reg(CFG_RATE_TOLERANCE, 32'h7fffffff);
        for (int i = 0; i < 8; i++) send_sample(random_sample(OP_MEASURE, 1));
        drain();
        write_reg(CFG_GYRO_SCALE, 0);
        write_reg(CFG_ACCEL_SCALE, 0);
        write_reg(CFG_SAMPLE_PERIOD, 0);
        write_reg(CFG_ACCEL_TOLERANCE, 0);
        write_reg(CFG_ANGLE_TOLERANCE, 0);
        write_reg(CFG_RATE_TOLERANCE, 0);
        for (int i = 0; i < 6; i++) send_sample(random_sample(OP_MEASURE, 1));
        drain();

        // random mid settings, measuring before calibration
        write_reg(CFG_GYRO_SCALE, $urandom_range(1000000, 90000000));
        write_reg(CFG_ACCEL_SCALE, $urandom_range(100000, 4000000));
        write_reg(CFG_SAMPLE_PERIOD, $urandom_range(1000000, 400000000));
        write_reg(CFG_ACCEL_TOLERANCE, $urandom_range(0, 60000));
        write_reg(CFG_ANGLE_TOLERANCE, $urandom_range(0, 60000));
        write_reg(CFG_RATE_TOLERANCE, $urandom_range(0, 60000));
        for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
            spread = ($urandom_range(0, 4) == 0);
            send_sample(random_sample($urandom_range(0, 5) == 0, spread));
        end
        drain();

        // defaults again, mixed transactions with a quiet tail
        write_reg(CFG_GYRO_SCALE, 4570000);
        write_reg(CFG_ACCEL_SCALE, 262144);
        write_reg(CFG_SAMPLE_PERIOD, 21474837);
        write_reg(CFG_ACCEL_TOLERANCE, 6554);
        write_reg(CFG_ANGLE_TOLERANCE, 6554);
        write_reg(CFG_RATE_TOLERANCE, 6554);
        for (int i = 0; i < RANDOM_ITEMS * 2 / 3; i++) begin
            if (i == RANDOM_ITEMS / 2) quiet_tail = 1;
            spread = ($urandom_range(0, 6) == 0);
            send_sample(random_sample($urandom_range(0, 9) == 0, spread));
        end
        drain();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
